/* rtl/sse_pkg.sv */
// Shared types and codes for the sorted set engine.
// Used by sse_cell and sorted_set_engine; depends on nothing else.
package sse_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned KindW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 5;

  // Request kinds (the unused code acts as a search)
  typedef enum logic [KindW-1:0] {
    KIND_SEARCH = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_DUP    = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Contents of one cell, handed to a neighbour on a shift
  typedef struct packed {
    logic                   valid;
    logic signed [KeyW-1:0] key;
  } cell_data_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic                   cmp_en;   // latch compare flags against cmp_key
    logic signed [KeyW-1:0] cmp_key;
    logic                   ins_en;   // open a slot and place ins_key
    logic                   rem_en;   // close the slot of the matching key
    logic signed [KeyW-1:0] ins_key;
  } cell_ctrl_t;

endpackage

/* rtl/sse_cell.sv */
// One storage cell of the sorted set chain: key, occupancy bit and compare flags.
// Depends on sse_pkg.
module sse_cell
  import sse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  cell_data_t lower,      // contents of the cell below
  input  logic       lower_lt,   // cell below holds a key smaller than the request
  input  cell_data_t upper,      // contents of the cell above
  output cell_data_t data,
  output logic       lt,
  output logic       eq
);

  cell_data_t data_r, data_nxt;
  logic       lt_r, eq_r;

  // Choose the next contents: keep, take the new key, or shift in a neighbour
  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins_en && !lt_r) begin
      if (lower_lt) begin
        data_nxt.valid = 1'b1;
        data_nxt.key   = ctrl.ins_key;
      end else begin
        data_nxt = lower;
      end
    end else if (ctrl.rem_en && !lt_r) begin
      data_nxt = upper;
    end
  end

  // Hold the occupancy bit under reset; keys need none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r.valid <= 1'b0;
    end else begin
      data_r.valid <= data_nxt.valid;
    end
    data_r.key <= data_nxt.key;
  end

  // Latch the compare flags for the request in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctrl.cmp_en) begin
      lt_r <= data_r.valid && (data_r.key < ctrl.cmp_key);
      eq_r <= data_r.valid && (data_r.key == ctrl.cmp_key);
    end
  end

  assign data = data_r;
  assign lt   = lt_r;
  assign eq   = eq_r;

endmodule

/* rtl/sorted_set_engine.sv */
// Top level of the sorted set engine: request control and the chain of cells.
// Depends on sse_pkg and sse_cell.
//
//  channel   | direction | tdata                              | tuser
//  in_       | slave     | [31:0] key                         | [1:0] kind
//  out_      | master    | [1:0] status, [6:2] occupancy      | -
//
// A request is compared, then applied: every cell compares its key with the request
// and latches the result, then the hit flag is gathered and the cells shift in
// one step. A new request is taken once the previous one has applied, also
// while its result waits in the output register. The apply step waits while
// the output register holds a result that is not taken. Reset empties the store at once.
module sorted_set_engine
  import sse_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] key
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [1:0] status, [6:2] occupancy, [7] zero
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  kind_t                  kind_r;
  logic signed [KeyW-1:0] key_r;
  logic [CntW-1:0]        count_r, count_nxt;
  logic                   out_valid_r;
  status_t                status_r, status_nxt;
  logic [OccW-1:0]        occ_r;

  cell_ctrl_t             ctrl;
  cell_data_t             cell_data [CAPACITY];
  logic [CAPACITY-1:0]    lt_vec, eq_vec, valid_vec;
  logic                   in_fire, apply, hit, full;
  logic [CntW+OccW-1:0]   count_ext;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign apply     = (state_r == S_APPLY) && (!out_valid_r || out_tready);
  assign hit       = |eq_vec;
  assign full      = (count_r == CntW'(CAPACITY));

  // Decide the outcome of the request in flight
  always_comb begin
    status_nxt = hit ? ST_OK : ST_ABSENT;
    count_nxt  = count_r;
    case (kind_r)
      KIND_INSERT: begin
        if (hit) begin
          status_nxt = ST_DUP;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_OK;
          count_nxt  = count_r + 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        status_nxt = hit ? ST_OK : ST_ABSENT;
      end
    endcase
  end

  // Drive the cell broadcast
  always_comb begin
    ctrl.cmp_en  = in_fire;
    ctrl.cmp_key = in_tdata;
    ctrl.ins_key = key_r;
    ctrl.ins_en  = apply && (kind_r == KIND_INSERT) && !hit && !full;
    ctrl.rem_en  = apply && (kind_r == KIND_REMOVE) && hit;
  end

  // Advance the request state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_APPLY;
      S_APPLY: if (apply)   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (apply) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the request and the result payload
  assign count_ext = {{OccW{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= kind_t'(in_tuser);
      key_r  <= in_tdata;
    end
    if (apply) begin
      status_r <= status_nxt;
      occ_r    <= count_ext[OccW-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, occ_r, status_r};

  // Build the chain of cells, lowest key in cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_data_t lower_d, upper_d;
    logic       lower_lt_d;

    if (i == 0) begin : g_bottom
      assign lower_d    = '0;
      assign lower_lt_d = 1'b1;
    end else begin : g_mid_lo
      assign lower_d    = cell_data[i-1];
      assign lower_lt_d = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign upper_d = '0;
    end else begin : g_mid_hi
      assign upper_d = cell_data[i+1];
    end

    sse_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .lower    (lower_d),
      .lower_lt (lower_lt_d),
      .upper    (upper_d),
      .data     (cell_data[i]),
      .lt       (lt_vec[i]),
      .eq       (eq_vec[i])
    );

    assign valid_vec[i] = cell_data[i].valid;
  end

  // Occupied cells always match the key count
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == count_r)
    else $error("occupied cells differ from key count");

  // Count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(CAPACITY))
    else $error("key count above capacity");

  // A full refusal is only reported with a full store
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    apply && status_nxt == ST_FULL |-> full && !hit)
    else $error("full status with free cells");

  // At most one key matches any request
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_APPLY |-> $onehot0(eq_vec))
    else $error("duplicate keys in store");

endmodule
